// ===== sv/stbg_pkg.sv =====
// ----------------------------------------------------------------------------
// stbg_pkg
// Shared types, codes and constant functions of the stepped tone burst
// generator: operation and register codes, stage sideband, sine quarter
// table contents and level table defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package stbg_pkg;

  // Default sizes
  localparam int LEVEL_DEPTH_DEF     = 16;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int PHASE_BITS_DEF      = 32;
  localparam int COUNT_BITS_DEF      = 24;

  // Fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int BURST_W  = 5;
  localparam int SINE_W   = 15;
  localparam int STEP_W   = 32;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 3;

  // Operation codes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_LEVEL   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LENGTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_GAIN  = 3'd4;

  // Register reset values
  localparam int BURST_LENGTH_RST = 2400;
  localparam int GAP_LENGTH_RST   = 7200;
  localparam int LEVEL_COUNT_RST  = 9;
  localparam int MASTER_GAIN_RST  = 16384;

  // Fixed point constants of the sine table build
  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Sideband that travels with each result through the pipeline
  typedef struct packed {
    logic               tone;
    logic               done;
    logic [BURST_W-1:0] number;
    logic               neg;
  } meta_t;

  // Quarter-wave entry: 32767 * sin(pi/2 * (i + 0.5) / 2^tbits), Q30 Taylor
  function automatic logic [SINE_W-1:0] quarter_entry(input int unsigned idx,
                                                      input int unsigned tbits);
    longint unsigned theta;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned r;
    theta = (HALF_PI_Q30 * (64'(2 * idx) + 64'd1)) >> (tbits + 1);
    x2 = (theta * theta) >> 30;
    t = Q30_ONE;
    t = Q30_ONE - (((x2 * t) >> 30) / 110);
    t = Q30_ONE - (((x2 * t) >> 30) / 72);
    t = Q30_ONE - (((x2 * t) >> 30) / 42);
    t = Q30_ONE - (((x2 * t) >> 30) / 20);
    t = Q30_ONE - (((x2 * t) >> 30) / 6);
    s = (theta * t) >> 30;
    r = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return SINE_W'(r);
  endfunction

  // Level table value after reset: 0.01 .. 0.9 in Q0.16, rest zero
  function automatic logic [LEVEL_W-1:0] default_level(input int unsigned idx);
    logic [LEVEL_W-1:0] v;
    case (idx)
      0:       v = 16'd655;
      1:       v = 16'd1311;
      2:       v = 16'd3277;
      3:       v = 16'd6554;
      4:       v = 16'd13107;
      5:       v = 16'd19661;
      6:       v = 16'd32768;
      7:       v = 16'd45875;
      8:       v = 16'd58982;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/stbg_level_mem.sv =====
// ----------------------------------------------------------------------------
// stbg_level_mem
// Level table: one synchronous memory with a registered read port and one
// valid flag per entry; an entry never written reads as its reset level.
// ----------------------------------------------------------------------------
`default_nettype none

module stbg_level_mem #(
  parameter int DEPTH = stbg_pkg::LEVEL_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [stbg_pkg::LEVEL_W-1:0] wr_data,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [stbg_pkg::LEVEL_W-1:0] rd_data
);

  logic [stbg_pkg::LEVEL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]             written;
  logic [stbg_pkg::LEVEL_W-1:0] mem_q;
  logic [stbg_pkg::LEVEL_W-1:0] dflt_q;
  logic                         written_q;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Track entries written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // Registered read port, hold while the pipeline stalls
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q     <= mem[rd_addr];
      written_q <= written[rd_addr];
      dflt_q    <= stbg_pkg::default_level(32'(rd_addr));
    end
  end

  assign rd_data = written_q ? mem_q : dflt_q;

endmodule

`default_nettype wire

// ===== sv/stbg_sine_rom.sv =====
// ----------------------------------------------------------------------------
// stbg_sine_rom
// Quarter-wave sine ROM with a registered read; quadrant folding is done
// on the address side by the caller.
// ----------------------------------------------------------------------------
`default_nettype none

module stbg_sine_rom #(
  parameter int TBITS = stbg_pkg::SINE_TABLE_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [TBITS-1:0]           rd_addr,
  output logic      [stbg_pkg::SINE_W-1:0] rd_data
);

  localparam int N = 1 << TBITS;

  wire [stbg_pkg::SINE_W-1:0] rom_data [N];

  // Fill the table at elaboration
  for (genvar g = 0; g < N; g++) begin : g_rom
    assign rom_data[g] = stbg_pkg::quarter_entry(g, TBITS);
  end

  // Registered read, hold while the pipeline stalls
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= rom_data[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/stbg_scale.sv =====
// ----------------------------------------------------------------------------
// stbg_scale
// Amplitude path: sine times level, times master gain, then round half
// away from zero and saturate to a signed 16-bit sample. Three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module stbg_scale (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [stbg_pkg::SINE_W-1:0]  sine_mag,
  input  wire logic [stbg_pkg::LEVEL_W-1:0] level,
  input  wire logic [stbg_pkg::GAIN_W-1:0]  gain,
  input  wire stbg_pkg::meta_t              meta_in,
  output logic      [stbg_pkg::SAMPLE_W-1:0] sample,
  output stbg_pkg::meta_t                   meta_out
);

  localparam int P1_W  = stbg_pkg::SINE_W + stbg_pkg::LEVEL_W;
  localparam int P2_W  = P1_W + stbg_pkg::GAIN_W;
  localparam int RND_W = P2_W + 1 - 30;

  logic [P1_W-1:0]  prod1;
  logic [P2_W-1:0]  prod2;
  stbg_pkg::meta_t  meta1;
  stbg_pkg::meta_t  meta2;
  logic [P2_W:0]    biased;
  logic [RND_W-1:0] rounded;
  logic [stbg_pkg::SAMPLE_W-1:0] sample_next;

  // First product: sine magnitude times level
  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= P1_W'(sine_mag) * P1_W'(level);
      meta1 <= meta_in;
    end
  end

  // Second product: times master gain
  always_ff @(posedge clk) begin
    if (en) begin
      prod2 <= P2_W'(prod1) * P2_W'(gain);
      meta2 <= meta1;
    end
  end

  // Round the magnitude, restore sign, saturate, blank outside tone
  always_comb begin
    biased  = (P2_W + 1)'(prod2) + ((P2_W + 1)'(1) << 29);
    rounded = biased[P2_W:30];
    if (!meta2.tone) begin
      sample_next = '0;
    end else if (!meta2.neg) begin
      sample_next = (rounded > RND_W'(32767)) ? 16'h7fff : rounded[15:0];
    end else begin
      sample_next = (rounded >= RND_W'(32768)) ? 16'h8000 : 16'(-rounded[15:0]);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      sample   <= sample_next;
      meta_out <= meta2;
    end
  end

endmodule

`default_nettype wire

// ===== sv/stepped_tone_burst_generator.sv =====
// ----------------------------------------------------------------------------
// stepped_tone_burst_generator
// Sequencer, phase accumulator and pipeline control of the tone burst
// generator; level memory, sine ROM and scaling path hang below.
// ----------------------------------------------------------------------------
// Each accepted item yields one result, registered in turn by the
// synchronous reads of the level memory and the sine ROM, the multiplies
// by level and by master gain, and the rounding into the output register.
// Items enter back to back at one per cycle; the whole pipeline holds
// while a result waits under out_stall, so in_stall follows
// out_valid && out_stall. Sequence counters and the phase advance at the
// input transfer, so a level write is seen by the very next tick. The level
// table comes out of reset with its default levels at once; no clearing
// pass. cfg_ready is always high; configure only while the block is idle.
`default_nettype none

module stepped_tone_burst_generator #(
  parameter int LEVEL_DEPTH     = stbg_pkg::LEVEL_DEPTH_DEF,
  parameter int SINE_TABLE_BITS = stbg_pkg::SINE_TABLE_BITS_DEF,
  parameter int PHASE_BITS      = stbg_pkg::PHASE_BITS_DEF,
  parameter int COUNT_BITS      = stbg_pkg::COUNT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     operation,
  input  wire logic [3:0]                     level_index,
  input  wire logic [stbg_pkg::LEVEL_W-1:0]   level_value,
  // output channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [stbg_pkg::SAMPLE_W-1:0]  sample,
  output logic                                in_burst,
  output logic                                sequence_done,
  output logic      [stbg_pkg::BURST_W-1:0]   burst_number,
  // configuration channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [stbg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [stbg_pkg::CFG_W-1:0]     cfg_data
);

  localparam int AW    = $clog2(LEVEL_DEPTH);
  localparam int POS_W = COUNT_BITS + 1;
  localparam int BW    = stbg_pkg::BURST_W;

  // Configuration registers
  logic [stbg_pkg::STEP_W-1:0] phase_step;
  logic [COUNT_BITS-1:0]       burst_length;
  logic [COUNT_BITS-1:0]       gap_length;
  logic [BW-1:0]               level_count;
  logic [stbg_pkg::GAIN_W-1:0] master_gain;

  // Sequence state
  logic [PHASE_BITS-1:0] phase;
  logic [PHASE_BITS-1:0] phase_next;
  logic [BW-1:0]         burst_count;
  logic [BW-1:0]         burst_count_next;
  logic [POS_W-1:0]      position;
  logic [POS_W-1:0]      position_next;

  // Pipeline control
  logic            advance;
  logic            accept;
  logic            v1;
  logic            v2;
  logic            v3;
  stbg_pkg::meta_t meta_next;
  stbg_pkg::meta_t meta1;
  stbg_pkg::meta_t meta_out;

  // Tick decode
  logic [BW-1:0]              active;
  logic                       tick_done;
  logic [POS_W-1:0]           pos_inc;
  logic [POS_W-1:0]           period;
  logic [1:0]                 quadrant;
  logic [SINE_TABLE_BITS-1:0] sine_addr;
  logic                       lvl_wr;
  logic [stbg_pkg::SINE_W-1:0]  sine_mag;
  logic [stbg_pkg::LEVEL_W-1:0] level;

  assign advance   = !(out_valid && out_stall);
  assign in_stall  = !advance;
  assign accept    = in_valid && advance;
  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step   <= '0;
      burst_length <= COUNT_BITS'(stbg_pkg::BURST_LENGTH_RST);
      gap_length   <= COUNT_BITS'(stbg_pkg::GAP_LENGTH_RST);
      level_count  <= BW'(stbg_pkg::LEVEL_COUNT_RST);
      master_gain  <= stbg_pkg::GAIN_W'(stbg_pkg::MASTER_GAIN_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        stbg_pkg::REG_PHASE_STEP:   phase_step   <= cfg_data;
        stbg_pkg::REG_BURST_LENGTH: burst_length <= cfg_data[COUNT_BITS-1:0];
        stbg_pkg::REG_GAP_LENGTH:   gap_length   <= cfg_data[COUNT_BITS-1:0];
        stbg_pkg::REG_LEVEL_COUNT:  level_count  <= cfg_data[BW-1:0];
        stbg_pkg::REG_MASTER_GAIN:  master_gain  <= cfg_data[stbg_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequence length, capped by the table depth
  assign active = (32'(level_count) < LEVEL_DEPTH) ? level_count : BW'(LEVEL_DEPTH);
  assign tick_done = burst_count >= active;
  assign pos_inc   = position + POS_W'(1);
  assign period    = POS_W'(burst_length) + POS_W'(gap_length);

  // Fold the phase onto the quarter table
  assign quadrant  = phase[PHASE_BITS-1 -: 2];
  assign sine_addr = quadrant[0] ? ~phase[PHASE_BITS-3 -: SINE_TABLE_BITS]
                                 : phase[PHASE_BITS-3 -: SINE_TABLE_BITS];

  // Next sequence state and sideband of this transfer
  always_comb begin
    phase_next       = phase;
    burst_count_next = burst_count;
    position_next    = position;
    meta_next.tone   = 1'b0;
    meta_next.neg    = quadrant[1];
    case (operation)
      stbg_pkg::OP_TICK: begin
        phase_next = phase + PHASE_BITS'(phase_step);
        if (!tick_done) begin
          meta_next.tone = position < POS_W'(burst_length);
          if (pos_inc >= period) begin
            position_next    = '0;
            burst_count_next = burst_count + BW'(1);
          end else begin
            position_next = pos_inc;
          end
        end
      end
      stbg_pkg::OP_RESTART: begin
        phase_next       = '0;
        burst_count_next = '0;
        position_next    = '0;
      end
      default: ;
    endcase
    if (operation == stbg_pkg::OP_TICK) begin
      meta_next.number = burst_count;
      meta_next.done   = tick_done;
    end else begin
      meta_next.number = burst_count_next;
      meta_next.done   = burst_count_next >= active;
    end
  end

  // Advance sequence state on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= '0;
      burst_count <= '0;
      position    <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      burst_count <= burst_count_next;
      position    <= position_next;
    end
  end

  // Stage valid flags, all held under a stalled result
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= accept;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // Sideband beside the memory read
  always_ff @(posedge clk) begin
    if (advance) begin
      meta1 <= meta_next;
    end
  end

  assign lvl_wr = accept && (operation == stbg_pkg::OP_LEVEL)
                  && (32'(level_index) < LEVEL_DEPTH);

  stbg_level_mem #(
    .DEPTH (LEVEL_DEPTH),
    .AW    (AW)
  ) u_level_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (lvl_wr),
    .wr_addr (AW'(level_index)),
    .wr_data (level_value),
    .rd_en   (advance),
    .rd_addr (AW'(burst_count)),
    .rd_data (level)
  );

  stbg_sine_rom #(
    .TBITS (SINE_TABLE_BITS)
  ) u_sine_rom (
    .clk     (clk),
    .rd_en   (advance),
    .rd_addr (sine_addr),
    .rd_data (sine_mag)
  );

  stbg_scale u_scale (
    .clk      (clk),
    .en       (advance),
    .sine_mag (sine_mag),
    .level    (level),
    .gain     (master_gain),
    .meta_in  (meta1),
    .sample   (sample),
    .meta_out (meta_out)
  );

  assign in_burst      = meta_out.tone;
  assign sequence_done = meta_out.done;
  assign burst_number  = meta_out.number;

endmodule

`default_nettype wire

// ===== sv/stbg_checker.sv =====
// ----------------------------------------------------------------------------
// stbg_checker
// Port-level checks of the tone burst generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stbg_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [stbg_pkg::SAMPLE_W-1:0]   sample,
  input wire logic                            in_burst,
  input wire logic                            sequence_done
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample))
    else $error("stalled result changed");

  // Silence outside tone parts
  a_gap_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_burst |-> sample == '0)
    else $error("nonzero sample outside a burst");

  // No tone once the sequence has ended
  a_done_no_tone: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_burst |-> !sequence_done)
    else $error("tone after end of sequence");

  // Input is only held back by a waiting result
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled with output free");

endmodule

bind stepped_tone_burst_generator stbg_checker u_stbg_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .sample        (sample),
  .in_burst      (in_burst),
  .sequence_done (sequence_done)
);

`default_nettype wire
